/* sv/rsl_pkg.sv */
// Shared widths, types and helper functions for the ray/sphere Lambert shader.
package rsl_pkg;

    localparam int CW        = 24;
    localparam int RW        = 23;
    localparam int EW        = 5;
    localparam int NORM_MSB  = 22;
    localparam int PW        = 2 * CW;
    localparam int SUMW      = PW + 2;
    localparam int RED_SHIFT = 17;
    localparam int SW        = 32;
    localparam int DSW       = 64;
    localparam int DW        = 62;
    localparam int SQW       = 31;
    localparam int XW        = SW + 1;
    localparam int XMW       = SW;
    localparam int T_SHIFT   = 28;
    localparam int QW        = 33;
    localparam int TW        = QW + 1;
    localparam int DTW       = CW + TW;
    localparam int HW        = 60;
    localparam int HEW       = 6;
    localparam int HNW       = 23;
    localparam int H_KEEP    = HNW - 2;
    localparam int HSW       = 2 * HNW;
    localparam int S3W       = HNW + 2;
    localparam int S2W       = 2 * S3W - 2;
    localparam int N2W       = HSW;
    localparam int MW        = N2W + 2;
    localparam int LW        = 64;
    localparam int PCW       = LW + 2;
    localparam int KW        = 8;
    localparam int LHS_SH_HI = 16;
    localparam int LHS_SH_LO = 9;
    localparam int AW        = 3;
    localparam int DATAW     = 32;
    localparam int CHW       = 8;

    localparam logic            REG_RADIUS   = 1'b0;
    localparam logic [RW-1:0]   RADIUS_RESET = 23'd32768;
    localparam logic [CHW-1:0]  ALPHA_OPAQUE = 8'hFF;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord [2:0] org;
        t_coord [2:0] dir;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic [SW-1:0]        a;
        logic signed [SW-1:0] hb;
        t_ray                 ray;
    } t_sq_side;

    typedef struct packed {
        logic hit;
        logic neg;
        t_ray ray;
    } t_div_side;

    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    function automatic logic [EW-1:0] msb_c(input logic [CW-1:0] v);
        logic [EW-1:0] p;
        p = '0;
        for (int i = 0; i < CW; i++) begin
            if (v[i]) p = EW'(i);
        end
        return p;
    endfunction

    function automatic logic [HEW-1:0] msb_h(input logic [HW-1:0] v);
        logic [HEW-1:0] p;
        p = '0;
        for (int i = 0; i < HW; i++) begin
            if (v[i]) p = HEW'(i);
        end
        return p;
    endfunction

    // divide by 2^17, truncating toward zero
    function automatic logic signed [SW-1:0] red_tz(input logic signed [SUMW-1:0] v);
        logic [SUMW-1:0] m;
        logic [SW-1:0]   q;
        m = v[SUMW-1] ? SUMW'(-v) : SUMW'(v);
        q = SW'(m >> RED_SHIFT);
        return v[SUMW-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

/* sv/rsl_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with side data.
module rsl_sqrt
    import rsl_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [DW-1:0]  i_rad,
    input  t_sq_side       i_side,
    output logic           o_valid,
    output logic [SQW-1:0] o_root,
    output t_sq_side       o_side
);

    logic           r_v    [SQW];
    logic [SQW+1:0] r_rem  [SQW];
    logic [SQW-1:0] r_root [SQW];
    logic [DW-1:0]  r_rad  [SQW];
    t_sq_side       r_side [SQW];

    genvar g;
    for (g = 0; g < SQW; g++) begin : g_stage
        logic           p_v;
        logic [SQW+1:0] p_rem;
        logic [SQW-1:0] p_root;
        logic [DW-1:0]  p_rad;
        t_sq_side       p_side;
        logic [SQW+3:0] sh_rem;
        logic [SQW+3:0] trial;
        logic [SQW+1:0] n_rem;
        logic [SQW-1:0] n_root;

        if (g == 0) begin : g_head
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_body
            assign p_v    = r_v[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            sh_rem = {p_rem, p_rad[DW-1 -: 2]};
            trial  = {2'b00, p_root, 2'b01};
            if (sh_rem >= trial) begin
                n_rem  = (SQW+2)'(sh_rem - trial);
                n_root = {p_root[SQW-2:0], 1'b1};
            end else begin
                n_rem  = (SQW+2)'(sh_rem);
                n_root = {p_root[SQW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_root[g] <= n_root;
            r_rad[g]  <= p_rad << 2;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_v[SQW-1];
    assign o_root  = r_root[SQW-1];
    assign o_side  = r_side[SQW-1];

endmodule

/* sv/rsl_div.sv */
// Pipelined restoring divider for the ray parameter, one quotient bit per stage.
module rsl_div
    import rsl_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [XMW-1:0] i_num,
    input  logic [SW-1:0]  i_den,
    input  t_div_side      i_side,
    output logic           o_valid,
    output logic [QW-1:0]  o_quo,
    output t_div_side      o_side
);

    logic          r_v    [QW];
    logic [SW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [QW-1:0] r_feed [QW];
    logic [SW-1:0] r_den  [QW];
    t_div_side     r_side [QW];

    genvar g;
    for (g = 0; g < QW; g++) begin : g_stage
        logic          p_v;
        logic [SW-1:0] p_rem;
        logic [QW-1:0] p_quo;
        logic [QW-1:0] p_feed;
        logic [SW-1:0] p_den;
        t_div_side     p_side;
        logic [SW:0]   sh;
        logic [SW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (g == 0) begin : g_head
            logic [XMW+T_SHIFT-1:0] dvd;
            assign dvd    = {i_num, T_SHIFT'(0)};
            assign p_v    = i_valid;
            assign p_rem  = SW'(dvd[XMW+T_SHIFT-1:QW]);
            assign p_quo  = '0;
            assign p_feed = dvd[QW-1:0];
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_body
            assign p_v    = r_v[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_quo  = r_quo[g-1];
            assign p_feed = r_feed[g-1];
            assign p_den  = r_den[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            sh = {p_rem, p_feed[QW-1]};
            if (sh >= {1'b0, p_den}) begin
                n_rem = SW'(sh - {1'b0, p_den});
                n_quo = {p_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = SW'(sh);
                n_quo = {p_quo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_quo[g]  <= n_quo;
            r_feed[g] <= p_feed << 1;
            r_den[g]  <= p_den;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* sv/ray_sphere_lambert_shader_unit.sv */
// Top level of the ray/sphere intersection and Lambert shading pipeline.
// Takes one ray per clock: busy is never raised, so a ray is transferred on
// every cycle that start is high. Each result leaves on the o_* ports for one
// cycle, flagged by o_done, in the order the rays came in. The depth is set
// mostly by the square root (31 stages, one root bit each) and the divider
// for the ray parameter (33 stages, one quotient bit each). The receiver
// cannot stall the pipe and must take each result in the cycle it is shown.
// Write the radius only while no ray is in flight.
module ray_sphere_lambert_shader_unit
    import rsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [CW-1:0]  i_origin_x,
    input  logic signed [CW-1:0]  i_origin_y,
    input  logic signed [CW-1:0]  i_origin_z,
    input  logic signed [CW-1:0]  i_dir_x,
    input  logic signed [CW-1:0]  i_dir_y,
    input  logic signed [CW-1:0]  i_dir_z,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [CHW-1:0]        o_red,
    output logic [CHW-1:0]        o_green,
    output logic [CHW-1:0]        o_blue,
    output logic [CHW-1:0]        o_alpha,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AW-1:0]         paddr,
    input  logic [DATAW-1:0]      pwdata,
    output logic [DATAW-1:0]      prdata,
    output logic                  pready
);

    // configuration
    logic [RW-1:0] r_radius, n_radius;

    always_comb begin
        n_radius = r_radius;
        if (psel && penable && pwrite && pready && paddr[AW-1] == REG_RADIUS) begin
            n_radius = pwdata[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else begin
            r_radius <= n_radius;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[AW-1] == REG_RADIUS) ? DATAW'(r_radius) : '0;
    assign busy   = 1'b0;

    // stage 1: normalising exponents
    t_ray          n_s1_ray, r_s1_ray;
    logic [RW-1:0] r_s1_rad;
    logic [EW-1:0] n_s1_ed, n_s1_eo, r_s1_ed, r_s1_eo;
    logic          n_s1_dz, r_s1_dz, r_s1_v;
    logic [CW-1:0] magd, mago;
    logic [EW-1:0] pd, po;

    always_comb begin
        n_s1_ray.org[0] = i_origin_x;
        n_s1_ray.org[1] = i_origin_y;
        n_s1_ray.org[2] = i_origin_z;
        n_s1_ray.dir[0] = i_dir_x;
        n_s1_ray.dir[1] = i_dir_y;
        n_s1_ray.dir[2] = i_dir_z;
        magd = mag_c(i_dir_x) | mag_c(i_dir_y) | mag_c(i_dir_z);
        mago = mag_c(i_origin_x) | mag_c(i_origin_y) | mag_c(i_origin_z) | CW'(r_radius);
        pd = msb_c(magd);
        po = msb_c(mago);
        n_s1_ed = (pd >= EW'(NORM_MSB)) ? '0 : EW'(NORM_MSB) - pd;
        n_s1_eo = (po >= EW'(NORM_MSB)) ? '0 : EW'(NORM_MSB) - po;
        n_s1_dz = (magd == '0);
    end

    always_ff @(posedge i_clk) begin
        r_s1_ray <= n_s1_ray;
        r_s1_rad <= r_radius;
        r_s1_ed  <= n_s1_ed;
        r_s1_eo  <= n_s1_eo;
        r_s1_dz  <= n_s1_dz;
    end

    // stage 2: scale up
    t_ray          n_s2_ray, r_s2_ray;
    logic [RW-1:0] r_s2_rad;
    logic          r_s2_dz, r_s2_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_ray.org[k] = r_s1_ray.org[k] << r_s1_eo;
            n_s2_ray.dir[k] = r_s1_ray.dir[k] << r_s1_ed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ray <= n_s2_ray;
        r_s2_rad <= r_s1_rad << r_s1_eo;
        r_s2_dz  <= r_s1_dz;
    end

    // stage 3: products
    logic signed [PW-1:0] n_s3_dd [3], n_s3_od [3], n_s3_oo [3];
    logic signed [PW-1:0] r_s3_dd [3], r_s3_od [3], r_s3_oo [3];
    logic [2*RW-1:0]      r_s3_rr;
    logic                 r_s3_dz, r_s3_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s3_dd[k] = PW'($signed(r_s2_ray.dir[k]) * $signed(r_s2_ray.dir[k]));
            n_s3_od[k] = PW'($signed(r_s2_ray.org[k]) * $signed(r_s2_ray.dir[k]));
            n_s3_oo[k] = PW'($signed(r_s2_ray.org[k]) * $signed(r_s2_ray.org[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_dd <= n_s3_dd;
        r_s3_od <= n_s3_od;
        r_s3_oo <= n_s3_oo;
        r_s3_rr <= (2*RW)'(r_s2_rad * r_s2_rad);
        r_s3_dz <= r_s2_dz;
    end

    t_ray r_s3_ray;
    always_ff @(posedge i_clk) begin
        r_s3_ray <= r_s2_ray;
    end

    // stage 4: quadratic coefficients
    logic signed [SUMW-1:0] sum_a, sum_hb, sum_c;
    logic [SW-1:0]          n_s4_a, r_s4_a;
    logic signed [SW-1:0]   n_s4_hb, n_s4_c, r_s4_hb, r_s4_c;
    t_ray                   r_s4_ray;
    logic                   r_s4_dz, r_s4_v;

    always_comb begin
        sum_a  = SUMW'(r_s3_dd[0]) + SUMW'(r_s3_dd[1]) + SUMW'(r_s3_dd[2]);
        sum_hb = SUMW'(r_s3_od[0]) + SUMW'(r_s3_od[1]) + SUMW'(r_s3_od[2]);
        sum_c  = SUMW'(r_s3_oo[0]) + SUMW'(r_s3_oo[1]) + SUMW'(r_s3_oo[2])
               - SUMW'($signed({1'b0, r_s3_rr}));
        n_s4_a  = SW'(red_tz(sum_a));
        n_s4_hb = red_tz(sum_hb);
        n_s4_c  = red_tz(sum_c);
    end

    always_ff @(posedge i_clk) begin
        r_s4_a   <= n_s4_a;
        r_s4_hb  <= n_s4_hb;
        r_s4_c   <= n_s4_c;
        r_s4_ray <= r_s3_ray;
        r_s4_dz  <= r_s3_dz;
    end

    // stage 5: discriminant products
    logic signed [DSW-1:0] r_s5_hb2, r_s5_ac;
    logic [SW-1:0]         r_s5_a;
    logic signed [SW-1:0]  r_s5_hb;
    t_ray                  r_s5_ray;
    logic                  r_s5_dz, r_s5_v;

    always_ff @(posedge i_clk) begin
        r_s5_hb2 <= DSW'(r_s4_hb * r_s4_hb);
        r_s5_ac  <= DSW'($signed(r_s4_a) * r_s4_c);
        r_s5_a   <= r_s4_a;
        r_s5_hb  <= r_s4_hb;
        r_s5_ray <= r_s4_ray;
        r_s5_dz  <= r_s4_dz;
    end

    // stage 6: discriminant
    logic signed [DSW-1:0] disc;
    t_sq_side              n_s6_side, r_s6_side;
    logic [DW-1:0]         r_s6_rad;
    logic                  r_s6_v;

    always_comb begin
        disc          = r_s5_hb2 - r_s5_ac;
        n_s6_side.hit = !r_s5_dz && !disc[DSW-1];
        n_s6_side.a   = r_s5_a;
        n_s6_side.hb  = r_s5_hb;
        n_s6_side.ray = r_s5_ray;
    end

    always_ff @(posedge i_clk) begin
        r_s6_side <= n_s6_side;
        r_s6_rad  <= disc[DW-1:0];
    end

    logic           sq_v;
    logic [SQW-1:0] sq_root;
    t_sq_side       sq_side;

    rsl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_v),
        .i_rad   (r_s6_rad),
        .i_side  (r_s6_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // numerator of the ray parameter
    logic signed [XW-1:0] xsum;
    logic [XMW-1:0]       n_x_mag, r_x_mag;
    logic [SW-1:0]        r_x_den;
    t_div_side            n_x_side, r_x_side;
    logic                 r_x_v;

    always_comb begin
        xsum = $signed({sq_side.hb[SW-1], sq_side.hb}) + $signed({2'b00, sq_root});
        n_x_mag = xsum[XW-1] ? XMW'(-xsum) : XMW'(xsum);
        n_x_side.hit = sq_side.hit;
        n_x_side.neg = !xsum[XW-1];
        n_x_side.ray = sq_side.ray;
    end

    always_ff @(posedge i_clk) begin
        r_x_mag  <= n_x_mag;
        r_x_den  <= sq_side.a;
        r_x_side <= n_x_side;
    end

    logic          dv_v;
    logic [QW-1:0] dv_quo;
    t_div_side     dv_side;

    rsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x_v),
        .i_num   (r_x_mag),
        .i_den   (r_x_den),
        .i_side  (r_x_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // signed ray parameter
    logic signed [TW-1:0] n_t_t, r_t_t;
    t_ray                 r_t_ray;
    logic                 r_t_hit, r_t_v;

    always_comb begin
        n_t_t = dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    end

    always_ff @(posedge i_clk) begin
        r_t_t   <= n_t_t;
        r_t_ray <= dv_side.ray;
        r_t_hit <= dv_side.hit;
    end

    // hit point: D * t
    logic signed [DTW-1:0] n_h1_dt [3], r_h1_dt [3];
    t_ray                  r_h1_ray;
    logic                  r_h1_hit, r_h1_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_h1_dt[k] = DTW'($signed(r_t_ray.dir[k]) * r_t_t);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1_dt  <= n_h1_dt;
        r_h1_ray <= r_t_ray;
        r_h1_hit <= r_t_hit;
    end

    // hit point: O * 2^28 + D * t
    logic signed [HW-1:0] n_h2_h [3], r_h2_h [3];
    logic                 r_h2_hit, r_h2_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_h2_h[k] = (HW'($signed(r_h1_ray.org[k])) << T_SHIFT) + HW'(r_h1_dt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h2_h   <= n_h2_h;
        r_h2_hit <= r_h1_hit;
    end

    // reduce: magnitudes and leading bit
    logic [HW-1:0]  n_q1_mag [3], r_q1_mag [3];
    logic [2:0]     n_q1_neg, r_q1_neg;
    logic [HW-1:0]  hor;
    logic [HEW-1:0] r_q1_p;
    logic           r_q1_nz, r_q1_hit, r_q1_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_q1_neg[k] = r_h2_h[k][HW-1];
            n_q1_mag[k] = r_h2_h[k][HW-1] ? HW'(-r_h2_h[k]) : HW'(r_h2_h[k]);
        end
        hor = n_q1_mag[0] | n_q1_mag[1] | n_q1_mag[2];
    end

    always_ff @(posedge i_clk) begin
        r_q1_mag <= n_q1_mag;
        r_q1_neg <= n_q1_neg;
        r_q1_p   <= msb_h(hor);
        r_q1_nz  <= (hor != '0);
        r_q1_hit <= r_h2_hit;
    end

    // reduce: shift down
    logic [HEW-1:0]        sh_h;
    logic [HNW-2:0]        hq [3];
    logic signed [HNW-1:0] n_q2_h [3], r_q2_h [3];
    logic                  r_q2_nz, r_q2_hit, r_q2_v;

    always_comb begin
        sh_h = (r_q1_p > HEW'(H_KEEP)) ? r_q1_p - HEW'(H_KEEP) : '0;
        for (int k = 0; k < 3; k++) begin
            hq[k] = (HNW-1)'(r_q1_mag[k] >> sh_h);
            n_q2_h[k] = r_q1_neg[k] ? -$signed({1'b0, hq[k]}) : $signed({1'b0, hq[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2_h   <= n_q2_h;
        r_q2_nz  <= r_q1_nz;
        r_q2_hit <= r_q1_hit;
    end

    // shade: sum and squares
    logic signed [S3W-1:0] n_q3_s3, r_q3_s3;
    logic [HSW-1:0]        n_q3_sq [3], r_q3_sq [3];
    logic                  n_q3_ok, r_q3_ok, r_q3_hit, r_q3_v;

    always_comb begin
        n_q3_s3 = S3W'(r_q2_h[0]) + S3W'(r_q2_h[1]) + S3W'(r_q2_h[2]);
        for (int k = 0; k < 3; k++) begin
            n_q3_sq[k] = HSW'(r_q2_h[k] * r_q2_h[k]);
        end
        n_q3_ok = r_q2_hit && r_q2_nz && (n_q3_s3 > 0);
    end

    always_ff @(posedge i_clk) begin
        r_q3_s3  <= n_q3_s3;
        r_q3_sq  <= n_q3_sq;
        r_q3_ok  <= n_q3_ok;
        r_q3_hit <= r_q2_hit;
    end

    // shade: |h|^2 * 3 and S^2
    logic [N2W-1:0]          n2;
    logic signed [2*S3W-1:0] s3sq;
    logic [MW-1:0]           r_q4_m;
    logic [S2W-1:0]          r_q4_s2;
    logic                    r_q4_ok, r_q4_hit, r_q4_v;

    always_comb begin
        n2   = r_q3_sq[0] + r_q3_sq[1] + r_q3_sq[2];
        s3sq = r_q3_s3 * r_q3_s3;
    end

    always_ff @(posedge i_clk) begin
        r_q4_m   <= (MW'(n2) << 1) + MW'(n2);
        r_q4_s2  <= s3sq[S2W-1:0];
        r_q4_ok  <= r_q3_ok;
        r_q4_hit <= r_q3_hit;
    end

    // shade: 65025 * S^2
    logic [LW-1:0] r_q5_lhs;
    logic [MW-1:0] r_q5_m;
    logic          r_q5_ok, r_q5_hit, r_q5_v;

    always_ff @(posedge i_clk) begin
        r_q5_lhs <= (LW'(r_q4_s2) << LHS_SH_HI) - (LW'(r_q4_s2) << LHS_SH_LO) + LW'(r_q4_s2);
        r_q5_m   <= r_q4_m;
        r_q5_ok  <= r_q4_ok;
        r_q5_hit <= r_q4_hit;
    end

    // largest k with 3*k^2*|h|^2 <= 65025*S^2, one bit of k per stage
    logic           r_k_v   [KW];
    logic [KW-1:0]  r_k_k   [KW];
    logic [PCW-1:0] r_k_p   [KW];
    logic [MW-1:0]  r_k_m   [KW];
    logic [LW-1:0]  r_k_lhs [KW];
    logic           r_k_ok  [KW];
    logic           r_k_hit [KW];

    genvar g;
    for (g = 0; g < KW; g++) begin : g_srch
        localparam int B = KW - 1 - g;
        logic           p_v, p_ok, p_hit;
        logic [KW-1:0]  p_k;
        logic [PCW-1:0] p_p;
        logic [MW-1:0]  p_m;
        logic [LW-1:0]  p_lhs;
        logic [KW:0]    inc;
        logic [PCW-1:0] term;
        logic [PCW-1:0] cand;
        logic [KW-1:0]  n_k;
        logic [PCW-1:0] n_p;

        if (g == 0) begin : g_head
            assign p_v   = r_q5_v;
            assign p_k   = '0;
            assign p_p   = '0;
            assign p_m   = r_q5_m;
            assign p_lhs = r_q5_lhs;
            assign p_ok  = r_q5_ok;
            assign p_hit = r_q5_hit;
        end else begin : g_body
            assign p_v   = r_k_v[g-1];
            assign p_k   = r_k_k[g-1];
            assign p_p   = r_k_p[g-1];
            assign p_m   = r_k_m[g-1];
            assign p_lhs = r_k_lhs[g-1];
            assign p_ok  = r_k_ok[g-1];
            assign p_hit = r_k_hit[g-1];
        end

        always_comb begin
            inc  = {p_k, 1'b0} + ((KW+1)'(1) << B);
            term = PCW'(p_m * inc);
            cand = p_p + (term << B);
            if (cand <= PCW'(p_lhs)) begin
                n_k = p_k | (KW'(1) << B);
                n_p = cand;
            end else begin
                n_k = p_k;
                n_p = p_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[g] <= 1'b0;
            end else begin
                r_k_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_k_k[g]   <= n_k;
            r_k_p[g]   <= n_p;
            r_k_m[g]   <= p_m;
            r_k_lhs[g] <= p_lhs;
            r_k_ok[g]  <= p_ok;
            r_k_hit[g] <= p_hit;
        end
    end

    // output register
    logic          r_done, r_hit;
    logic [CHW-1:0] r_red;

    always_ff @(posedge i_clk) begin
        r_hit <= r_k_hit[KW-1];
        r_red <= r_k_ok[KW-1] ? r_k_k[KW-1] : '0;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_x_v  <= 1'b0;
            r_t_v  <= 1'b0;
            r_h1_v <= 1'b0;
            r_h2_v <= 1'b0;
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
            r_q3_v <= 1'b0;
            r_q4_v <= 1'b0;
            r_q5_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_x_v  <= sq_v;
            r_t_v  <= dv_v;
            r_h1_v <= r_t_v;
            r_h2_v <= r_h1_v;
            r_q1_v <= r_h2_v;
            r_q2_v <= r_q1_v;
            r_q3_v <= r_q2_v;
            r_q4_v <= r_q3_v;
            r_q5_v <= r_q4_v;
            r_done <= r_k_v[KW-1];
        end
    end

    assign o_done  = r_done;
    assign o_hit   = r_hit;
    assign o_red   = r_red;
    assign o_green = '0;
    assign o_blue  = r_red;
    assign o_alpha = ALPHA_OPAQUE;

endmodule

/* tb/ray_shade_checker.sv */
// Checker for the ray/sphere shader: tracks the radius, predicts pixels, compares results.
`timescale 1ns / 1ps
module ray_shade_checker
    import rsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  t_coord               i_origin_x,
    input  t_coord               i_origin_y,
    input  t_coord               i_origin_z,
    input  t_coord               i_dir_x,
    input  t_coord               i_dir_y,
    input  t_coord               i_dir_z,
    input  logic                 i_done,
    input  logic                 i_hit,
    input  logic [CHW-1:0]       i_red,
    input  logic [CHW-1:0]       i_green,
    input  logic [CHW-1:0]       i_blue,
    input  logic [CHW-1:0]       i_alpha,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [DATAW-1:0]     pwdata,
    input  logic                 pready,
    output int                   o_fail_count,
    output int                   o_pixels_pending,
    output int                   o_pixels_seen,
    output int                   o_hits_seen,
    output int                   o_lit_seen
);

    localparam longint NORM = 64'sd4194304;

    typedef struct packed {
        logic           hit;
        logic [CHW-1:0] red;
        logic [CHW-1:0] green;
        logic [CHW-1:0] blue;
        logic [CHW-1:0] alpha;
    } t_pixel;

    logic [RW-1:0] radius_q;
    t_pixel        pixel_q[$];

    function automatic longint unsigned abs64(input longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint pow2_up(input longint unsigned m);
        longint f;
        f = 1;
        while (m < NORM) begin
            m = m * 2;
            f = f * 2;
        end
        return f;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_pixel shade_ray(input t_coord org[3], input t_coord dir[3],
                                         input logic [RW-1:0] rad);
        t_pixel          px;
        longint          o[3], d[3], h[3];
        longint          rr, f, aa, hb, cc, qa, qhb, qc, disc, s, t, s3, dv;
        longint unsigned m, n2, lhs, red;
        int              sh;
        px = '{hit: 1'b0, red: '0, green: '0, blue: '0, alpha: ALPHA_OPAQUE};
        for (int k = 0; k < 3; k++) begin
            o[k] = longint'(org[k]);
            d[k] = longint'(dir[k]);
        end
        rr = longint'(rad);
        m = 0;
        for (int k = 0; k < 3; k++) if (abs64(d[k]) > m) m = abs64(d[k]);
        if (m == 0) return px;
        f = pow2_up(m);
        for (int k = 0; k < 3; k++) d[k] = d[k] * f;
        m = rr;
        for (int k = 0; k < 3; k++) if (abs64(o[k]) > m) m = abs64(o[k]);
        if (m != 0) begin
            f = pow2_up(m);
            for (int k = 0; k < 3; k++) o[k] = o[k] * f;
            rr = rr * f;
        end
        aa = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        hb = o[0] * d[0] + o[1] * d[1] + o[2] * d[2];
        cc = o[0] * o[0] + o[1] * o[1] + o[2] * o[2] - rr * rr;
        qa = aa / 131072;
        qhb = hb / 131072;
        qc = cc / 131072;
        disc = qhb * qhb - qa * qc;
        if (disc < 0) return px;
        s = longint'(root64(disc));
        t = -((qhb + s) * 64'sd268435456) / qa;
        for (int k = 0; k < 3; k++) h[k] = o[k] * 64'sd268435456 + d[k] * t;
        px.hit = 1'b1;
        red = 0;
        m = 0;
        for (int k = 0; k < 3; k++) if (abs64(h[k]) > m) m = abs64(h[k]);
        if (m != 0) begin
            sh = 0;
            while ((m >> sh) >= NORM) sh++;
            dv = 64'sd1 << sh;
            for (int k = 0; k < 3; k++) h[k] = h[k] / dv;
            s3 = h[0] + h[1] + h[2];
            if (s3 > 0) begin
                n2 = 0;
                for (int k = 0; k < 3; k++) n2 += longint'(h[k] * h[k]);
                lhs = 64'd65025 * s3 * s3;
                while (red < 255 && 3 * (red + 1) * (red + 1) * n2 <= lhs) red++;
            end
        end
        px.red = CHW'(red);
        px.blue = CHW'(red);
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_coord org[3], dir[3];
        t_pixel want, got;
        if (!i_rst_n) begin
            radius_q = RADIUS_RESET;
            pixel_q.delete();
            o_fail_count = 0;
            o_pixels_seen = 0;
            o_hits_seen = 0;
            o_lit_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[AW-1:2] == REG_RADIUS)
                radius_q = pwdata[RW-1:0];
            if (i_done) begin
                got = '{hit: i_hit, red: i_red, green: i_green, blue: i_blue, alpha: i_alpha};
                o_pixels_seen++;
                if (pixel_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                end else begin
                    want = pixel_q.pop_front();
                    if (want.hit) o_hits_seen++;
                    if (want.red != 0) o_lit_seen++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: pixel mismatch exp %p got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (start && !busy) begin
                org = '{i_origin_x, i_origin_y, i_origin_z};
                dir = '{i_dir_x, i_dir_y, i_dir_z};
                pixel_q = {pixel_q, shade_ray(org, dir, radius_q)};
            end
        end
        o_pixels_pending = pixel_q.size();
    end

endmodule

/* tb/ray_sphere_lambert_shader_unit_tb.sv */
// Testbench top for the ray/sphere shader: ray stimulus, radius writes and verdict.
`timescale 1ns / 1ps
module ray_sphere_lambert_shader_unit_tb
    import rsl_pkg::*;
();

    localparam logic [AW-3:0] REG_SPARE = 1'b1;
    localparam int            IDLE_LIMIT = 4000;
    localparam int            RAYS_PER_PHASE = 305;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_coord          org_x = '0, org_y = '0, org_z = '0;
    t_coord          dir_x = '0, dir_y = '0, dir_z = '0;
    logic            o_done, o_hit;
    logic [CHW-1:0]  o_red, o_green, o_blue, o_alpha;
    logic            psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0]   paddr = '0;
    logic [DATAW-1:0] pwdata = '0;
    logic [DATAW-1:0] prdata;
    logic            pready;
    int              fail_count, pixels_pending, pixels_seen, hits_seen, lit_seen;
    int              idle_pct = 0;
    int              rays_sent = 0;
    int              quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    ray_sphere_lambert_shader_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_origin_x(org_x), .i_origin_y(org_y), .i_origin_z(org_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .o_done(o_done), .o_hit(o_hit), .o_red(o_red), .o_green(o_green),
        .o_blue(o_blue), .o_alpha(o_alpha),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ray_shade_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_origin_x(org_x), .i_origin_y(org_y), .i_origin_z(org_z),
        .i_dir_x(dir_x), .i_dir_y(dir_y), .i_dir_z(dir_z),
        .i_done(o_done), .i_hit(o_hit), .i_red(o_red), .i_green(o_green),
        .i_blue(o_blue), .i_alpha(o_alpha),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pixels_pending(pixels_pending),
        .o_pixels_seen(pixels_seen), .o_hits_seen(hits_seen), .o_lit_seen(lit_seen)
    );

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_ray(input t_coord ox, input t_coord oy, input t_coord oz,
                            input t_coord dx, input t_coord dy, input t_coord dz);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        {org_x, org_y, org_z, dir_x, dir_y, dir_z} = {ox, oy, oz, dx, dy, dz};
        do @(posedge i_clk); while (busy);
        rays_sent++;
    endtask

    task automatic apb_write(input logic [AW-1:0] addr, input logic [DATAW-1:0] data);
        @(negedge i_clk);
        start = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (pixels_pending != 0) @(negedge i_clk);
    endtask

    function automatic t_coord rnd_coord;
        case ($urandom_range(5, 0))
            0:       return t_coord'($urandom);
            1:       return $urandom_range(1, 0) ? t_coord'(-8388608) : t_coord'(8388607);
            2:       return t_coord'(0);
            default: return t_coord'($signed($urandom) >>> $urandom_range(31, 8));
        endcase
    endfunction

    // ray from a random point aimed roughly at the centre
    task automatic send_aimed;
        longint o[3], d[3], jit;
        int     sh;
        sh = $urandom_range(23, 1);
        for (int k = 0; k < 3; k++) o[k] = $signed($urandom) >>> (32 - sh);
        jit = (64'sd1 << sh) >> $urandom_range(6, 1);
        for (int k = 0; k < 3; k++) begin
            d[k] = -o[k] + $signed($urandom % (2 * jit + 1)) - jit;
            if (d[k] > 8388607) d[k] = 8388607;
            if (d[k] < -8388608) d[k] = -8388608;
        end
        send_ray(t_coord'(o[0]), t_coord'(o[1]), t_coord'(o[2]),
                 t_coord'(d[0]), t_coord'(d[1]), t_coord'(d[2]));
    endtask

    task automatic send_mixed(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99, 0) < 70) send_aimed();
            else send_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                          rnd_coord(), rnd_coord(), rnd_coord());
        end
    endtask

    initial begin
        logic [DATAW-1:0] radii[5];
        radii = '{32'd1, 32'd8388607, 32'd65536, 32'hFF80_4000, 32'd0};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rays at the reset radius
        idle_pct = 18;
        send_ray('0, '0, -24'sd131072, '0, '0, '0);            // zero direction
        send_ray('0, '0, -24'sd131072, '0, '0, 24'sd65536);    // head on
        send_ray(-24'sd131072, -24'sd131072, -24'sd131072, 24'sd1, 24'sd1, 24'sd1);
        send_ray(24'sd131072, 24'sd131072, 24'sd131072,
                 -24'sd1, -24'sd1, -24'sd1);                   // lit side
        send_ray(24'sd131072, '0, '0, '0, 24'sd65536, '0);     // miss
        send_ray('0, '0, '0, 24'sd65536, '0, '0);              // from inside
        send_ray('0, '0, '0, -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_ray('0, '0, '0, 24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_ray(-24'sd8388608, -24'sd8388608, -24'sd8388608,
                 24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_ray(24'sd8388607, 24'sd8388607, 24'sd8388607,
                 -24'sd8388608, -24'sd8388608, -24'sd8388608);
        send_ray(-24'sd8388608, '0, '0, 24'sd8388607, '0, '0);
        send_ray('0, -24'sd8388608, '0, '0, 24'sd1, '0);
        send_ray('0, '0, 24'sd8388607, '0, '0, -24'sd1);
        send_ray(-24'sd32768, '0, '0, 24'sd1, '0, '0);         // grazing start on surface
        send_ray(-24'sd65536, 24'sd32768, '0, 24'sd65536, '0, '0); // tangent
        send_ray(24'hFFFFFF, 24'h000001, 24'h800000, 24'h7FFFFF, 24'h000000, 24'h800000);

        drain();
        apb_write({REG_SPARE, 2'b00}, 32'd12345);  // unmapped register, ignored
        send_mixed(20);
        for (int p = 0; p < 5; p++) begin
            drain();
            apb_write({REG_RADIUS, 2'b00}, radii[p]);
            idle_pct = (p < 2) ? 18 : (p < 4) ? 71 : 0;
            send_mixed(RAYS_PER_PHASE);
        end
        // origin at the centre with a point sphere
        send_ray('0, '0, '0, 24'sd65536, 24'sd65536, '0);
        drain();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d rays over 6 radius settings; %0d results, %0d hits, %0d lit.",
                 rays_sent, pixels_seen, hits_seen, lit_seen);
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
